@@ src/bbfa_pkg.sv @@
// ---------------------------------------------------------------------------
// bbfa_pkg
// Shared types and constants of the bitmap best-fit allocator.
// ---------------------------------------------------------------------------
package bbfa_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned MAX_LENGTH = 32768;

  // operation codes on func_i
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;         // capture input word
    logic    calc;         // block count, offset, scan init
    logic    scan_rd;      // read map byte at scan pointer
    logic    scan_proc;    // fold registered map byte into run search
    logic    scan_final;   // closing pass: map end counts as used
    logic    alloc_setup;  // range := best run head, result address
    logic    free_setup;   // range := blocks covered by free
    logic    rmw_rd;       // read map byte at range pointer
    logic    rmw_wr;       // write masked byte, advance pointer
    logic    clr_wr;       // write zero byte, advance pointer
    logic    out_load;     // load output register
    status_e out_code;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic len_bad;
    logic free_bad;
    logic found;
    logic rd_last;
    logic ptr_end;
    logic ptr_at_last;
    logic out_busy;
  } dp_sts_t;

endpackage

@@ src/bbfa_dp.sv @@
// ---------------------------------------------------------------------------
// bbfa_dp
// Datapath: bitmap memory, run search, range update, output register.
// ---------------------------------------------------------------------------
module bbfa_dp #(
  parameter int unsigned BLOCK_SIZE = 128,
  parameter int unsigned MAP_BYTES  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bbfa_pkg::dp_cmd_t             cmd_i,
  output bbfa_pkg::dp_sts_t             sts_o,
  input  logic                          cfg_valid_i,
  input  logic [bbfa_pkg::ADDR_W-1:0]   cfg_data_i,
  input  logic                          func_i,
  input  logic [bbfa_pkg::LEN_W-1:0]    length_bytes_i,
  input  logic [bbfa_pkg::ADDR_W-1:0]   free_address_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output bbfa_pkg::status_e             status_o,
  output logic [bbfa_pkg::ADDR_W-1:0]   alloc_address_o
);
  import bbfa_pkg::*;

  localparam int unsigned SH         = $clog2(BLOCK_SIZE);
  localparam int unsigned MAP_BLOCKS = MAP_BYTES * 8;
  localparam int unsigned AW         = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int unsigned IDX_W      = AW + 3;
  localparam int unsigned BLK_W      = $clog2(MAP_BLOCKS + 1);
  localparam int unsigned NEED_W     = LEN_W + 1 - SH;
  localparam int unsigned CNT_W      = (BLK_W > NEED_W) ? BLK_W : NEED_W;

  // item
  logic                func_q;
  logic [LEN_W-1:0]    len_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [ADDR_W-1:0]   base_q;
  logic [NEED_W-1:0]   need_q;
  logic [ADDR_W-1:0]   offset_q;

  // run search
  logic [AW-1:0]       rd_ptr_q;
  logic [AW-1:0]       rd_idx_q;
  logic [7:0]          rdata_q;
  logic [CNT_W-1:0]    run_len_q, run_len_d;
  logic [IDX_W-1:0]    run_st_q, run_st_d;
  logic [CNT_W-1:0]    best_len_q, best_len_d;
  logic [IDX_W-1:0]    best_st_q, best_st_d;
  logic                found_q, found_d;

  // range update
  logic [IDX_W-1:0]    rf_q, rl_q;
  logic [AW-1:0]       ptr_q;
  logic [7:0]          mask;
  logic [ADDR_W-1:0]   res_addr_q;

  // output register
  logic                out_valid_q;
  status_e             status_q;
  logic [ADDR_W-1:0]   out_addr_q;

  logic [7:0]          mem_q [MAP_BYTES];
  logic                mem_we;
  logic [AW-1:0]       mem_raddr;
  logic [7:0]          mem_wdata;

  logic [ADDR_W:0]     last_byte;
  logic [ADDR_W:0]     need_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i) begin
      base_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      len_q  <= length_bytes_i;
      addr_q <= free_address_i;
    end
  end

  assign need_sum = {{(ADDR_W-LEN_W){1'b0}}, 1'b0, len_q} + (ADDR_W+1)'(BLOCK_SIZE - 1);
  assign last_byte = {1'b0, offset_q} + {{(ADDR_W-LEN_W+1){1'b0}}, len_q}
                   - (ADDR_W+1)'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      need_q   <= need_sum[LEN_W:SH];
      offset_q <= addr_q - base_q;
    end
  end

  // eight bits per cycle through the run tracker
  always_comb begin
    logic [7:0] bits;
    run_len_d  = run_len_q;
    run_st_d   = run_st_q;
    best_len_d = best_len_q;
    best_st_d  = best_st_q;
    found_d    = found_q;
    bits       = cmd_i.scan_final ? 8'hFF : rdata_q;
    for (int i = 0; i < 8; i++) begin
      if (!bits[i]) begin
        if (run_len_d == '0) begin
          run_st_d = {rd_idx_q, 3'(i)};
        end
        run_len_d = run_len_d + CNT_W'(1);
      end else begin
        if (run_len_d >= CNT_W'(need_q) && (!found_d || run_len_d < best_len_d)) begin
          found_d    = 1'b1;
          best_st_d  = run_st_d;
          best_len_d = run_len_d;
        end
        run_len_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      run_len_q <= '0;
      rd_ptr_q  <= '0;
      ptr_q     <= '0;
    end else begin
      if (cmd_i.calc) begin
        found_q   <= 1'b0;
        run_len_q <= '0;
        rd_ptr_q  <= '0;
      end else begin
        if (cmd_i.scan_proc) begin
          found_q   <= found_d;
          run_len_q <= run_len_d;
        end
        if (cmd_i.scan_rd) begin
          rd_ptr_q <= rd_ptr_q + AW'(1);
        end
      end
      if (cmd_i.alloc_setup) begin
        ptr_q <= best_st_q[IDX_W-1:3];
      end else if (cmd_i.free_setup) begin
        ptr_q <= offset_q[SH+IDX_W-1:SH+3];
      end else if (cmd_i.rmw_wr || cmd_i.clr_wr) begin
        ptr_q <= ptr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_proc) begin
      run_st_q   <= run_st_d;
      best_len_q <= best_len_d;
      best_st_q  <= best_st_d;
    end
    if (cmd_i.calc) begin
      res_addr_q <= '0;
    end else if (cmd_i.alloc_setup) begin
      rf_q       <= best_st_q;
      rl_q       <= best_st_q + IDX_W'(need_q) - IDX_W'(1);
      res_addr_q <= base_q + {{(ADDR_W-IDX_W-SH){1'b0}}, best_st_q, {SH{1'b0}}};
    end else if (cmd_i.free_setup) begin
      rf_q <= offset_q[SH+IDX_W-1:SH];
      rl_q <= last_byte[SH+IDX_W-1:SH];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[i] = ({ptr_q, 3'(i)} >= rf_q) && ({ptr_q, 3'(i)} <= rl_q);
    end
  end

  // single-port bitmap memory
  assign mem_we    = cmd_i.rmw_wr || cmd_i.clr_wr;
  assign mem_raddr = cmd_i.scan_rd ? rd_ptr_q : ptr_q;
  assign mem_wdata = cmd_i.clr_wr ? 8'h00 :
                     (func_q == FUNC_FREE) ? (rdata_q & ~mask) : (rdata_q | mask);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[ptr_q] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd || cmd_i.rmw_rd) begin
      rdata_q  <= mem_q[mem_raddr];
      rd_idx_q <= mem_raddr;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q   <= cmd_i.out_code;
      out_addr_q <= (cmd_i.out_code == ST_OK) ? res_addr_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign alloc_address_o = out_addr_q;

  assign sts_o.is_free     = (func_q == FUNC_FREE);
  assign sts_o.len_bad     = (len_q == '0) || (len_q > LEN_W'(MAX_LENGTH));
  assign sts_o.free_bad    = (last_byte >> SH) >= (ADDR_W+1)'(MAP_BLOCKS);
  assign sts_o.found       = found_q;
  assign sts_o.rd_last     = (rd_ptr_q == AW'(MAP_BYTES - 1));
  assign sts_o.ptr_end     = (ptr_q == AW'(MAP_BYTES - 1));
  assign sts_o.ptr_at_last = (ptr_q == rl_q[IDX_W-1:3]);
  assign sts_o.out_busy    = out_valid_q && out_stall_i;

endmodule

@@ src/bbfa_ctrl.sv @@
// ---------------------------------------------------------------------------
// bbfa_ctrl
// Sequencer: clear pass, map scan, read-modify-write of a block range.
// ---------------------------------------------------------------------------
module bbfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bbfa_pkg::dp_sts_t sts_i,
  output bbfa_pkg::dp_cmd_t cmd_o
);
  import bbfa_pkg::*;

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_CALC       = 4'd2;
  localparam logic [3:0] S_SCAN_FIRST = 4'd3;
  localparam logic [3:0] S_SCAN       = 4'd4;
  localparam logic [3:0] S_SCAN_TAIL  = 4'd5;
  localparam logic [3:0] S_SCAN_FIN   = 4'd6;
  localparam logic [3:0] S_ALLOC_CHK  = 4'd7;
  localparam logic [3:0] S_FREE_CHK   = 4'd8;
  localparam logic [3:0] S_RMW_RD     = 4'd9;
  localparam logic [3:0] S_RMW_WR     = 4'd10;
  localparam logic [3:0] S_RESULT     = 4'd11;

  logic [3:0] state_q, state_d;
  status_e    code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    code_d         = code_q;
    cmd_o          = '0;
    cmd_o.out_code = code_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.ptr_end) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        if (sts_i.len_bad) begin
          code_d  = ST_BAD;
          state_d = S_RESULT;
        end else if (sts_i.is_free) begin
          state_d = S_FREE_CHK;
        end else begin
          state_d = S_SCAN_FIRST;
        end
      end
      S_SCAN_FIRST: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = sts_i.rd_last ? S_SCAN_TAIL : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_rd   = 1'b1;
        cmd_o.scan_proc = 1'b1;
        if (sts_i.rd_last) begin
          state_d = S_SCAN_TAIL;
        end
      end
      S_SCAN_TAIL: begin
        cmd_o.scan_proc = 1'b1;
        state_d         = S_SCAN_FIN;
      end
      S_SCAN_FIN: begin
        cmd_o.scan_proc  = 1'b1;
        cmd_o.scan_final = 1'b1;
        state_d          = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        if (sts_i.found) begin
          cmd_o.alloc_setup = 1'b1;
          code_d            = ST_OK;
          state_d           = S_RMW_RD;
        end else begin
          code_d  = ST_NO_SPACE;
          state_d = S_RESULT;
        end
      end
      S_FREE_CHK: begin
        if (sts_i.free_bad) begin
          code_d  = ST_BAD;
          state_d = S_RESULT;
        end else begin
          cmd_o.free_setup = 1'b1;
          code_d           = ST_OK;
          state_d          = S_RMW_RD;
        end
      end
      S_RMW_RD: begin
        cmd_o.rmw_rd = 1'b1;
        state_d      = S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd_o.rmw_wr = 1'b1;
        if (sts_i.ptr_at_last) begin
          state_d = S_RESULT;
        end else begin
          state_d = S_RMW_RD;
        end
      end
      S_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

@@ src/bitmap_best_fit_allocator.sv @@
// ---------------------------------------------------------------------------
// bitmap_best_fit_allocator
// Best-fit block allocator over a one-bit-per-block map, top level.
// ---------------------------------------------------------------------------
// One input word is an allocate or a free; each yields exactly one result
// word (status, address). After reset the map memory is cleared one byte per
// cycle, so in_stall_o stays high until the whole map is cleared, before the
// first word is taken. The block works on one word at a time. An allocate
// scans the whole map for the best-fitting run, since the single map memory
// port reads one byte per cycle for the best-fit scan; then each map byte the
// granted run touches costs a read and a write. An allocate with no fitting
// run ends after the scan. A free costs a read and a write for each map byte
// it touches. The defaults are 32 map bytes and 128-byte blocks. A zero or
// oversized length is rejected, as is a free that runs past the map.
// A finished result waits in the output register while the next word is
// accepted; the block only holds a new result back while the output is
// stalled. data_base is taken through the configuration channel, which is
// always ready and must only be written while the block is idle.
// BLOCK_SIZE must be a power of two.
module bitmap_best_fit_allocator #(
  parameter int unsigned BLOCK_SIZE = 128,
  parameter int unsigned MAP_BYTES  = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bbfa_pkg::ADDR_W-1:0] cfg_data_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [bbfa_pkg::LEN_W-1:0]  length_bytes_i,
  input  logic [bbfa_pkg::ADDR_W-1:0] free_address_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [bbfa_pkg::ADDR_W-1:0] alloc_address_o
);
  import bbfa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  status_e status;

  // register write needs no back-pressure
  assign cfg_ready_o = 1'b1;

  bbfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bbfa_dp #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .MAP_BYTES  (MAP_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .length_bytes_i  (length_bytes_i),
    .free_address_i  (free_address_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status),
    .alloc_address_o (alloc_address_o)
  );

  assign status_o = status;

endmodule

@@ src/bbfa_checker.sv @@
// ---------------------------------------------------------------------------
// bbfa_checker
// Port-level checks of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
module bbfa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  status_o,
  input logic [bbfa_pkg::ADDR_W-1:0] alloc_address_o
);
  import bbfa_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
                                   && $stable(alloc_address_o))
    else $error("stalled result word changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_NO_SPACE)
                    || (status_o == ST_BAD))
    else $error("undefined status code");

  // only a granted allocate carries an address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> alloc_address_o == '0)
    else $error("nonzero address on failed request");

  // one word in flight: intake closes right after a word is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while one is in progress");

endmodule

bind bitmap_best_fit_allocator bbfa_checker u_bbfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .alloc_address_o (alloc_address_o)
);
